FILE: hw/rtl/ksf_pkg.sv
`default_nettype none
package ksf_pkg;

    localparam int FRAC_BITS   = 8;
    localparam int POS_WIDTH   = 32;

    localparam int COORD_W     = 24;
    localparam int WHEEL_W     = 16;
    localparam int HEIGHT_W    = 31;
    localparam int OFFSET_W    = 32;

    localparam int DECAY_Q16   = 62259;
    localparam int EASE_Q16    = 13107;
    localparam int LOCK_PIXELS = 20;
    localparam int WHEEL_STEP  = 50;

    typedef logic signed [COORD_W-1:0]  t_coord;
    typedef logic signed [WHEEL_W-1:0]  t_wheel;
    typedef logic        [HEIGHT_W-1:0] t_height;
    typedef logic signed [OFFSET_W-1:0] t_offset;

endpackage
`default_nettype wire

FILE: hw/rtl/ksf_in_if.sv
`default_nettype none
interface ksf_in_if;
    logic            valid;
    logic            ready;
    ksf_pkg::t_coord pointer_x;
    ksf_pkg::t_coord pointer_y;
    logic            press_edge;
    logic            button_held;
    ksf_pkg::t_wheel wheel_delta;

    modport source (
        output valid, pointer_x, pointer_y, press_edge, button_held, wheel_delta,
        input  ready
    );
    modport sink (
        input  valid, pointer_x, pointer_y, press_edge, button_held, wheel_delta,
        output ready
    );
endinterface
`default_nettype wire

FILE: hw/rtl/ksf_out_if.sv
`default_nettype none
interface ksf_out_if;
    logic             valid;
    logic             ready;
    ksf_pkg::t_offset scroll_offset;
    logic             dragging;

    modport source (
        output valid, scroll_offset, dragging,
        input  ready
    );
    modport sink (
        input  valid, scroll_offset, dragging,
        output ready
    );
endinterface
`default_nettype wire

FILE: hw/rtl/ksf_step.sv
`default_nettype none
module ksf_step #(
    parameter int FRAC_BITS = ksf_pkg::FRAC_BITS,
    parameter int POS_WIDTH = ksf_pkg::POS_WIDTH
) (
    input  wire ksf_pkg::t_coord        i_px,
    input  wire ksf_pkg::t_coord        i_py,
    input  wire logic                   i_press,
    input  wire logic                   i_held,
    input  wire ksf_pkg::t_wheel        i_wheel,
    input  wire ksf_pkg::t_height       i_height,
    input  wire logic signed [POS_WIDTH-1:0] i_scroll,
    input  wire logic signed [POS_WIDTH-1:0] i_target,
    input  wire logic signed [POS_WIDTH-1:0] i_vel,
    input  wire logic                   i_drag,
    input  wire logic                   i_undec,
    input  wire ksf_pkg::t_coord        i_start_x,
    input  wire ksf_pkg::t_coord        i_start_y,
    input  wire ksf_pkg::t_coord        i_prev_y,
    output logic signed [POS_WIDTH-1:0] o_scroll,
    output logic signed [POS_WIDTH-1:0] o_target,
    output logic signed [POS_WIDTH-1:0] o_vel,
    output logic                        o_drag,
    output logic                        o_undec,
    output ksf_pkg::t_coord             o_start_x,
    output ksf_pkg::t_coord             o_start_y,
    output ksf_pkg::t_coord             o_prev_y,
    output ksf_pkg::t_offset            o_offset
);

    localparam int P  = POS_WIDTH;
    localparam int CW = ksf_pkg::COORD_W;
    localparam int DW = CW + 1;
    localparam int OW = (P > ksf_pkg::OFFSET_W) ? P : ksf_pkg::OFFSET_W;
    localparam int EW = OW + 1;

    localparam logic [DW-1:0]         LOCK_DIST = DW'(ksf_pkg::LOCK_PIXELS << FRAC_BITS);
    localparam logic signed [P-1:0]   PMAX      = {1'b0, {(P-1){1'b1}}};
    localparam logic signed [P-1:0]   PMIN      = {1'b1, {(P-1){1'b0}}};
    localparam logic signed [EW-1:0]  PMAX_E    = EW'(PMAX);
    localparam logic signed [17:0]    DECAY_S   = 18'(ksf_pkg::DECAY_Q16);
    localparam logic signed [15:0]    EASE_S    = 16'(ksf_pkg::EASE_Q16);
    localparam logic signed [OW-1:0]  OMAX      = OW'(32'sh7fffffff);
    localparam logic signed [OW-1:0]  OMIN      = -OMAX - OW'(1);
    localparam logic signed [P+17:0]  RND16     = (P+18)'(65535);
    localparam logic signed [P+16:0]  RND16_E   = (P+17)'(65535);

    function automatic logic signed [P-1:0] f_sat(input logic signed [P:0] v);
        logic signed [P-1:0] r;
        begin
            if (v[P] != v[P-1]) begin
                r = v[P] ? PMIN : PMAX;
            end else begin
                r = v[P-1:0];
            end
            return r;
        end
    endfunction

    function automatic logic signed [P-1:0] f_rb(input logic signed [P-1:0] y,
                                                  input logic signed [EW-1:0] h);
        logic signed [EW-1:0] ye;
        logic signed [EW-1:0] df;
        logic signed [EW-1:0] r;
        begin
            ye = EW'(y);
            r  = ye;
            df = ye - h;
            if (ye > h) begin
                r = ye - (df >>> 1);
            end else if (ye < 0) begin
                r = ye - ((ye + EW'(1)) >>> 1);
            end
            return r[P-1:0];
        end
    endfunction

    logic signed [EW-1:0]  h_eff;
    logic signed [P-1:0]   tgt;
    logic                  drag;
    logic                  undec;
    ksf_pkg::t_coord       sx;
    ksf_pkg::t_coord       sy;
    ksf_pkg::t_coord       prev;
    logic signed [DW-1:0]  dx_s;
    logic signed [DW-1:0]  dy_s;
    logic [DW-1:0]         dx;
    logic [DW-1:0]         dy;
    logic signed [DW-1:0]  d;
    logic signed [P-1:0]   tgt_d;
    logic signed [P+2:0]   sm;
    logic signed [P+2:0]   sm_q;
    logic signed [P-1:0]   vel_d;
    logic signed [P-1:0]   t1;
    logic signed [P-1:0]   s1;
    logic signed [P+17:0]  vp;
    logic signed [P+17:0]  vp_q;
    logic signed [21:0]    w50;
    logic signed [P-1:0]   t2;
    logic signed [P-1:0]   t3;
    logic signed [P:0]     ed;
    logic signed [P+16:0]  ep;
    logic signed [P+16:0]  ep_q;
    logic signed [OW-1:0]  so;

    always_comb begin
        h_eff = EW'(i_height);
        if (h_eff > PMAX_E) begin
            h_eff = PMAX_E;
        end
    end

    always_comb begin
        tgt   = i_target;
        drag  = i_drag;
        undec = i_undec;
        sx    = i_start_x;
        sy    = i_start_y;
        prev  = i_prev_y;

        if (i_press) begin
            tgt   = i_scroll;
            drag  = 1'b1;
            undec = 1'b1;
            sx    = i_px;
            sy    = i_py;
            prev  = i_py;
        end

        dx_s = DW'(i_px) - DW'(sx);
        dy_s = DW'(i_py) - DW'(sy);
        dx   = dx_s[DW-1] ? DW'(-dx_s) : DW'(dx_s);
        dy   = dy_s[DW-1] ? DW'(-dy_s) : DW'(dy_s);

        if (drag) begin
            if (undec) begin
                if (dx > dy) begin
                    if (dx > LOCK_DIST) begin
                        drag = 1'b0;
                    end
                end else if (dy > LOCK_DIST) begin
                    undec = 1'b0;
                end
            end
            if (!i_held) begin
                drag = 1'b0;
                tgt  = i_scroll;
            end
        end

        // drag path
        d     = DW'(prev) - DW'(i_py);
        tgt_d = f_sat((P+1)'(tgt) + (P+1)'(d));
        sm    = (P+3)'(i_vel) + ((P+3)'(i_vel) <<< 1) + (P+3)'(d);
        sm_q  = sm[P+2] ? ((sm + (P+3)'(3)) >>> 2) : (sm >>> 2);
        vel_d = f_sat(sm_q[P:0]);

        // coast path
        t1   = f_sat((P+1)'(tgt) + (P+1)'(i_vel));
        s1   = f_sat((P+1)'(i_scroll) + (P+1)'(i_vel));
        vp   = (P+18)'(i_vel) * (P+18)'(DECAY_S);
        vp_q = vp[P+17] ? ((vp + RND16) >>> 16) : (vp >>> 16);
        w50  = (22'(i_wheel) <<< 5) + (22'(i_wheel) <<< 4) + (22'(i_wheel) <<< 1);
        t2   = f_sat((P+1)'(t1) - (P+1)'(w50));
        t3   = f_rb(t2, h_eff);
        ed   = (P+1)'(t3) - (P+1)'(s1);
        ep   = (P+17)'(ed) * (P+17)'(EASE_S);
        ep_q = ep[P+16] ? ((ep + RND16_E) >>> 16) : (ep >>> 16);

        if (drag) begin
            o_target = tgt_d;
            o_vel    = vel_d;
            o_prev_y = i_py;
            o_scroll = f_rb(tgt_d, h_eff);
        end else begin
            o_target = t3;
            o_vel    = vp_q[P-1:0];
            o_prev_y = prev;
            o_scroll = f_sat((P+1)'(s1) + ep_q[P:0]);
        end

        o_drag    = drag;
        o_undec   = undec;
        o_start_x = sx;
        o_start_y = sy;

        so = OW'(o_scroll);
        if (so > OMAX) begin
            so = OMAX;
        end else if (so < OMIN) begin
            so = OMIN;
        end
        o_offset = so[ksf_pkg::OFFSET_W-1:0];
    end

endmodule
`default_nettype wire

FILE: hw/rtl/kinetic_scroll_filter_unit.sv
`default_nettype none
// Kinetic vertical scroll filter with rubber-band bounds. Each input transaction is one
// display frame (pointer position, press edge, button-held bit, wheel delta) and yields
// exactly one output transaction carrying the scroll offset and the drag flag. A new
// input transaction is accepted every clock cycle while the output side takes results:
// the frame is held in an input register, and the whole frame update (drag lock, velocity
// smoothing and decay, wheel, rubber-band clamp, easing) runs in one pass of logic into
// the state and output registers, so throughput is one transaction per cycle while the
// output side takes results. content_height is to be written through i_cfg_we/i_cfg_wdata
// only while no transaction is in flight, a rule on the user that the block does not enforce.
module kinetic_scroll_filter_unit #(
    parameter int FRAC_BITS = ksf_pkg::FRAC_BITS,
    parameter int POS_WIDTH = ksf_pkg::POS_WIDTH
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire ksf_pkg::t_height i_cfg_wdata,
    ksf_in_if.sink                i_in,
    ksf_out_if.source             o_out
);

    logic                        r_in_valid;
    ksf_pkg::t_coord             r_px;
    ksf_pkg::t_coord             r_py;
    logic                        r_press;
    logic                        r_held;
    ksf_pkg::t_wheel             r_wheel;

    ksf_pkg::t_height            r_height;
    logic signed [POS_WIDTH-1:0] r_scroll;
    logic signed [POS_WIDTH-1:0] r_target;
    logic signed [POS_WIDTH-1:0] r_vel;
    logic                        r_drag;
    logic                        r_undec;
    ksf_pkg::t_coord             r_start_x;
    ksf_pkg::t_coord             r_start_y;
    ksf_pkg::t_coord             r_prev_y;

    logic                        r_out_valid;
    ksf_pkg::t_offset            r_out_offset;
    logic                        r_out_dragging;

    logic signed [POS_WIDTH-1:0] n_scroll;
    logic signed [POS_WIDTH-1:0] n_target;
    logic signed [POS_WIDTH-1:0] n_vel;
    logic                        n_drag;
    logic                        n_undec;
    ksf_pkg::t_coord             n_start_x;
    ksf_pkg::t_coord             n_start_y;
    ksf_pkg::t_coord             n_prev_y;
    ksf_pkg::t_offset            n_offset;

    logic                        advance;
    logic                        in_take;

    assign advance     = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready  = !r_in_valid || advance;
    assign in_take     = i_in.valid && i_in.ready;

    assign o_out.valid         = r_out_valid;
    assign o_out.scroll_offset = r_out_offset;
    assign o_out.dragging      = r_out_dragging;

    ksf_step #(
        .FRAC_BITS (FRAC_BITS),
        .POS_WIDTH (POS_WIDTH)
    ) u_step (
        .i_px      (r_px),
        .i_py      (r_py),
        .i_press   (r_press),
        .i_held    (r_held),
        .i_wheel   (r_wheel),
        .i_height  (r_height),
        .i_scroll  (r_scroll),
        .i_target  (r_target),
        .i_vel     (r_vel),
        .i_drag    (r_drag),
        .i_undec   (r_undec),
        .i_start_x (r_start_x),
        .i_start_y (r_start_y),
        .i_prev_y  (r_prev_y),
        .o_scroll  (n_scroll),
        .o_target  (n_target),
        .o_vel     (n_vel),
        .o_drag    (n_drag),
        .o_undec   (n_undec),
        .o_start_x (n_start_x),
        .o_start_y (n_start_y),
        .o_prev_y  (n_prev_y),
        .o_offset  (n_offset)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_px    <= i_in.pointer_x;
            r_py    <= i_in.pointer_y;
            r_press <= i_in.press_edge;
            r_held  <= i_in.button_held;
            r_wheel <= i_in.wheel_delta;
        end
    end

    // filter state and config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_height  <= '0;
            r_scroll  <= '0;
            r_target  <= '0;
            r_vel     <= '0;
            r_drag    <= 1'b0;
            r_undec   <= 1'b0;
            r_start_x <= '0;
            r_start_y <= '0;
            r_prev_y  <= '0;
        end else begin
            if (i_cfg_we) begin
                r_height <= i_cfg_wdata;
            end
            if (advance) begin
                r_scroll  <= n_scroll;
                r_target  <= n_target;
                r_vel     <= n_vel;
                r_drag    <= n_drag;
                r_undec   <= n_undec;
                r_start_x <= n_start_x;
                r_start_y <= n_start_y;
                r_prev_y  <= n_prev_y;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_offset   <= n_offset;
            r_out_dragging <= n_drag;
        end
    end

endmodule
`default_nettype wire
